FILE: sv/gdc_pkg.sv
// Shared types and constants for the gamepad deadzone conditioner.
package gdc_pkg;

    localparam int RootW    = 24;
    localparam int RemW     = 48;
    localparam int DivW     = 58;
    localparam int QuotW    = 16;
    localparam int NumLanes = 4;

    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_LT = 2;
    localparam int LANE_RT = 3;

    localparam logic [1:0] REG_STICK_DZ = 2'd0;
    localparam logic [1:0] REG_TRIG_DZ  = 2'd1;
    localparam logic [1:0] REG_DIGITAL  = 2'd2;

    typedef enum logic [1:0] {
        STK_PASS,
        STK_ZERO,
        STK_SCALE
    } stk_mode_t;

    typedef struct packed {
        logic [1:0]  port;
        logic [15:0] key;
        stk_mode_t   mode;
        logic [7:0]  x_hi;
        logic [7:0]  y_hi;
        logic        x_neg;
        logic        y_neg;
        logic [15:0] x_mag;
        logic [15:0] y_mag;
        logic        lt_fix;
        logic [7:0]  lt_val;
        logic        rt_fix;
        logic [7:0]  rt_val;
        logic [14:0] lt_num;
        logic [14:0] lt_den;
        logic [14:0] rt_num;
        logic [14:0] rt_den;
    } side_t;

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DivW-1:0]  rem;
        logic [DivW-1:0]  dv;
        logic [QuotW-1:0] q;
        logic             ovf;
    } div_lane_t;

    typedef div_lane_t [NumLanes-1:0] div_bus_t;

endpackage

FILE: sv/gamepad_deadzone_conditioner_top.sv
// Top level of the gamepad deadzone conditioner: front stage, root and divider chains, output.
//
// Takes one controller sample per beat and returns one report per beat, at a sustained rate
// of one sample per cycle while m_ready stays high. Each beat passes 44 registers: one front
// stage loaded at the accepting edge, 24 square-root digit cells for the stick radius, a
// multiply stage, a dividend stage, 16 divider cells that run the stick and trigger
// quotients side by side, and the output register.
// Each stage holds its own beat and moves as soon as the stage after it has room, so gaps
// close up while the output waits. Write the configuration registers only while no sample is
// in flight.
module gamepad_deadzone_conditioner_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_port,
    input  logic [9:0]  s_buttons,
    input  logic        s_l_pressed,
    input  logic        s_r_pressed,
    input  logic        s_l2_pressed,
    input  logic        s_r2_pressed,
    input  logic signed [15:0] s_stick_x,
    input  logic signed [15:0] s_stick_y,
    input  logic [14:0] s_left_trigger_raw,
    input  logic [14:0] s_right_trigger_raw,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_port_out,
    output logic [15:0] m_key_code,
    output logic signed [7:0] m_stick_x_out,
    output logic signed [7:0] m_stick_y_out,
    output logic [7:0]  m_left_trigger,
    output logic [7:0]  m_right_trigger
);
    import gdc_pkg::*;

    localparam int NumRoot = RootW;
    localparam int NumDiv  = QuotW;
    localparam logic [15:0] KEY_MAP [10] = '{
        16'h0004, 16'h0400, 16'h0000, 16'h0008, 16'h0010,
        16'h0020, 16'h0040, 16'h0080, 16'h0002, 16'h0200
    };

    typedef struct packed {
        logic        fix;
        logic [7:0]  val;
        logic [14:0] num;
        logic [14:0] den;
    } trig_t;

    function automatic trig_t trig_prep(input logic [14:0] raw, input logic btn,
                                        input logic btn2, input logic digital,
                                        input logic [15:0] td);
        trig_t t;
        t.fix = 1'b1;
        t.val = 8'h00;
        t.num = raw - td[14:0];
        t.den = 15'(17'h08000 - {1'b0, td});
        if (digital) begin
            t.val = btn ? 8'hFF : (btn2 ? 8'h7F : 8'h00);
        end else if (raw == 15'd0) begin
            t.val = btn2 ? 8'hFF : 8'h00;
        end else if (td == 16'd0) begin
            t.val = raw[14:7];
        end else if ({1'b0, raw} > td) begin
            t.fix = 1'b0;
        end
        return t;
    endfunction

    function automatic logic [14:0] quot_clamp(input div_lane_t l);
        return (l.ovf || l.q[QuotW-1]) ? 15'h7FFF : l.q[14:0];
    endfunction

    // configuration
    logic [15:0] stick_dz_reg;
    logic [15:0] trig_dz_reg;
    logic        digital_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_dz_reg <= 16'd0;
            trig_dz_reg  <= 16'd0;
            digital_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STICK_DZ: stick_dz_reg <= cfg_data;
                REG_TRIG_DZ:  trig_dz_reg  <= cfg_data;
                REG_DIGITAL:  digital_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front stage
    logic               front_valid_reg;
    side_t              front_side_reg;
    sq_t                front_sq_reg;
    side_t              front_side_next;
    logic signed [31:0] x_sq;
    logic signed [31:0] y_sq;
    logic [31:0]        r_sq;
    trig_t              lt_prep;
    trig_t              rt_prep;

    logic               sq_valid [NumRoot+1];
    logic               sq_ready [NumRoot+1];
    side_t              sq_side  [NumRoot+1];
    sq_t                sq_data  [NumRoot+1];

    assign s_ready = !front_valid_reg || sq_ready[0];

    always_comb begin
        x_sq    = s_stick_x * s_stick_x;
        y_sq    = s_stick_y * s_stick_y;
        r_sq    = {1'b0, x_sq[30:0]} + {1'b0, y_sq[30:0]};
        lt_prep = trig_prep(s_left_trigger_raw, s_l_pressed, s_l2_pressed, digital_reg,
                            trig_dz_reg);
        rt_prep = trig_prep(s_right_trigger_raw, s_r_pressed, s_r2_pressed, digital_reg,
                            trig_dz_reg);
        front_side_next.port = s_port;
        front_side_next.key  = 16'hFFFF;
        for (int i = 0; i < 10; i++) begin
            if (s_buttons[i]) begin
                front_side_next.key = front_side_next.key & ~KEY_MAP[i];
            end
        end
        if (stick_dz_reg == 16'd0) begin
            front_side_next.mode = STK_PASS;
        end else if (stick_dz_reg[15]) begin
            front_side_next.mode = STK_ZERO;
        end else begin
            front_side_next.mode = STK_SCALE;
        end
        front_side_next.x_hi   = s_stick_x[15:8];
        front_side_next.y_hi   = s_stick_y[15:8];
        front_side_next.x_neg  = s_stick_x[15];
        front_side_next.y_neg  = s_stick_y[15];
        front_side_next.x_mag  = s_stick_x[15] ? 16'(-s_stick_x) : s_stick_x;
        front_side_next.y_mag  = s_stick_y[15] ? 16'(-s_stick_y) : s_stick_y;
        front_side_next.lt_fix = lt_prep.fix;
        front_side_next.lt_val = lt_prep.val;
        front_side_next.lt_num = lt_prep.num;
        front_side_next.lt_den = lt_prep.den;
        front_side_next.rt_fix = rt_prep.fix;
        front_side_next.rt_val = rt_prep.val;
        front_side_next.rt_num = rt_prep.num;
        front_side_next.rt_den = rt_prep.den;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            front_side_reg    <= front_side_next;
            // radius carries 8 fraction bits
            front_sq_reg.rem  <= {r_sq, 16'h0000};
            front_sq_reg.root <= '0;
        end
    end

    // square-root chain
    assign sq_valid[0] = front_valid_reg;
    assign sq_side[0]  = front_side_reg;
    assign sq_data[0]  = front_sq_reg;

    for (genvar k = 0; k < NumRoot; k++) begin : g_root
        gdc_sqrt_cell #(.Bit(NumRoot - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[k]),
            .in_ready  (sq_ready[k]),
            .in_side   (sq_side[k]),
            .in_sq     (sq_data[k]),
            .out_valid (sq_valid[k+1]),
            .out_ready (sq_ready[k+1]),
            .out_side  (sq_side[k+1]),
            .out_sq    (sq_data[k+1])
        );
    end

    // multiply stage
    logic        mul_valid_reg;
    side_t       mul_side_reg;
    logic [39:0] mul_nx_reg;
    logic [39:0] mul_ny_reg;
    logic [39:0] mul_den_reg;
    logic        mul_ready;
    logic [24:0] diff;
    logic [RootW-1:0] r8;
    side_t       mul_side_next;
    logic        quo_ready;

    assign mul_ready          = !mul_valid_reg || quo_ready;
    assign sq_ready[NumRoot]  = mul_ready;
    assign r8                 = sq_data[NumRoot].root;

    always_comb begin
        diff          = {1'b0, r8} - {1'b0, stick_dz_reg, 8'h00};
        mul_side_next = sq_side[NumRoot];
        // radius at or inside the deadzone rescales to zero
        if (mul_side_next.mode == STK_SCALE && (diff[24] || diff == 25'd0)) begin
            mul_side_next.mode = STK_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= sq_valid[NumRoot];
        end
        if (mul_ready && sq_valid[NumRoot]) begin
            mul_side_reg <= mul_side_next;
            mul_nx_reg   <= sq_side[NumRoot].x_mag * diff[23:0];
            mul_ny_reg   <= sq_side[NumRoot].y_mag * diff[23:0];
            mul_den_reg  <= (16'h8000 - stick_dz_reg) * r8;
        end
    end

    // dividend stage: N = num*2^16 + den, D = 2*den, rounds to nearest
    logic     quo_valid_reg;
    side_t    quo_side_reg;
    div_bus_t quo_div_reg;
    div_bus_t quo_div_next;

    logic     dv_valid [NumDiv+1];
    logic     dv_ready [NumDiv+1];
    side_t    dv_side  [NumDiv+1];
    div_bus_t dv_data  [NumDiv+1];

    assign quo_ready = !quo_valid_reg || dv_ready[0];

    always_comb begin
        quo_div_next[LANE_X].rem  = {2'b00, mul_nx_reg, 16'h0000} + DivW'(mul_den_reg);
        quo_div_next[LANE_Y].rem  = {2'b00, mul_ny_reg, 16'h0000} + DivW'(mul_den_reg);
        quo_div_next[LANE_X].dv   = {17'd0, mul_den_reg, 1'b0};
        quo_div_next[LANE_Y].dv   = {17'd0, mul_den_reg, 1'b0};
        quo_div_next[LANE_LT].rem = DivW'({mul_side_reg.lt_num, 16'h0000})
                                    + DivW'(mul_side_reg.lt_den);
        quo_div_next[LANE_RT].rem = DivW'({mul_side_reg.rt_num, 16'h0000})
                                    + DivW'(mul_side_reg.rt_den);
        quo_div_next[LANE_LT].dv  = DivW'({mul_side_reg.lt_den, 1'b0});
        quo_div_next[LANE_RT].dv  = DivW'({mul_side_reg.rt_den, 1'b0});
        for (int i = 0; i < NumLanes; i++) begin
            quo_div_next[i].q   = '0;
            quo_div_next[i].ovf = quo_div_next[i].rem >= (quo_div_next[i].dv << QuotW);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_valid_reg <= 1'b0;
        end else if (quo_ready) begin
            quo_valid_reg <= mul_valid_reg;
        end
        if (quo_ready && mul_valid_reg) begin
            quo_side_reg <= mul_side_reg;
            quo_div_reg  <= quo_div_next;
        end
    end

    // divider chain
    assign dv_valid[0] = quo_valid_reg;
    assign dv_side[0]  = quo_side_reg;
    assign dv_data[0]  = quo_div_reg;

    for (genvar k = 0; k < NumDiv; k++) begin : g_div
        gdc_div_cell #(.Bit(NumDiv - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .in_side   (dv_side[k]),
            .in_div    (dv_data[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .out_side  (dv_side[k+1]),
            .out_div   (dv_data[k+1])
        );
    end

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_port_reg;
    logic [15:0] out_key_reg;
    logic [7:0]  out_x_reg;
    logic [7:0]  out_y_reg;
    logic [7:0]  out_lt_reg;
    logic [7:0]  out_rt_reg;
    logic        out_ready;
    side_t       fin_side;
    div_bus_t    fin_div;
    logic [14:0] qx, qy, qlt, qrt;
    logic [15:0] vx, vy;
    logic [7:0]  x_next, y_next, lt_next, rt_next;

    assign out_ready        = !out_valid_reg || m_ready;
    assign dv_ready[NumDiv] = out_ready;
    assign fin_side         = dv_side[NumDiv];
    assign fin_div          = dv_data[NumDiv];

    always_comb begin
        qx  = quot_clamp(fin_div[LANE_X]);
        qy  = quot_clamp(fin_div[LANE_Y]);
        qlt = quot_clamp(fin_div[LANE_LT]);
        qrt = quot_clamp(fin_div[LANE_RT]);
        vx  = fin_side.x_neg ? 16'(-{1'b0, qx}) : {1'b0, qx};
        vy  = fin_side.y_neg ? 16'(-{1'b0, qy}) : {1'b0, qy};
        unique case (fin_side.mode)
            STK_PASS: begin
                x_next = fin_side.x_hi;
                y_next = fin_side.y_hi;
            end
            STK_SCALE: begin
                x_next = vx[15:8];
                y_next = vy[15:8];
            end
            default: begin
                x_next = 8'h00;
                y_next = 8'h00;
            end
        endcase
        lt_next = fin_side.lt_fix ? fin_side.lt_val : qlt[14:7];
        rt_next = fin_side.rt_fix ? fin_side.rt_val : qrt[14:7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= dv_valid[NumDiv];
        end
        if (out_ready && dv_valid[NumDiv]) begin
            out_port_reg <= fin_side.port;
            out_key_reg  <= fin_side.key;
            out_x_reg    <= x_next;
            out_y_reg    <= y_next;
            out_lt_reg   <= lt_next;
            out_rt_reg   <= rt_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_port_out      = out_port_reg;
    assign m_key_code      = out_key_reg;
    assign m_stick_x_out   = out_x_reg;
    assign m_stick_y_out   = out_y_reg;
    assign m_left_trigger  = out_lt_reg;
    assign m_right_trigger = out_rt_reg;

endmodule

FILE: sv/gdc_sqrt_cell.sv
// One digit cell of the pipelined radius square root.
module gdc_sqrt_cell #(
    parameter int Bit = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gdc_pkg::side_t in_side,
    input  gdc_pkg::sq_t   in_sq,
    output logic          out_valid,
    input  logic          out_ready,
    output gdc_pkg::side_t out_side,
    output gdc_pkg::sq_t   out_sq
);
    import gdc_pkg::*;

    localparam logic [RemW-1:0]  TrialBit = RemW'(1) << (2 * Bit);
    localparam logic [RootW-1:0] RootBit  = RootW'(1) << Bit;

    logic            valid_reg;
    side_t           side_reg;
    sq_t             sq_reg;
    sq_t             sq_next;
    logic [RemW-1:0] trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        trial   = ({{(RemW - RootW){1'b0}}, in_sq.root} << (Bit + 1)) | TrialBit;
        sq_next = in_sq;
        if (in_sq.rem >= trial) begin
            sq_next.rem  = in_sq.rem - trial;
            sq_next.root = in_sq.root | RootBit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            side_reg <= in_side;
            sq_reg   <= sq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_sq    = sq_reg;

endmodule

FILE: sv/gdc_div_cell.sv
// One quotient-bit cell of the four-lane restoring divider.
module gdc_div_cell #(
    parameter int Bit = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdc_pkg::side_t    in_side,
    input  gdc_pkg::div_bus_t in_div,
    output logic              out_valid,
    input  logic              out_ready,
    output gdc_pkg::side_t    out_side,
    output gdc_pkg::div_bus_t out_div
);
    import gdc_pkg::*;

    localparam logic [QuotW-1:0] QBit = QuotW'(1) << Bit;

    logic     valid_reg;
    side_t    side_reg;
    div_bus_t div_reg;
    div_bus_t div_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        div_next = in_div;
        for (int i = 0; i < NumLanes; i++) begin
            if (in_div[i].rem >= (in_div[i].dv << Bit)) begin
                div_next[i].rem = in_div[i].rem - (in_div[i].dv << Bit);
                div_next[i].q   = in_div[i].q | QBit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

endmodule
